@@ design/srx_pkg.sv @@
package srx_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned ROT_W  = 5;

   localparam logic [HASH_W-1:0] HASH_MUL = 32'h2D89_135D;
   localparam logic [HASH_W-1:0] HASH_ADD = 32'h4497_5913;
   localparam logic [HASH_W-1:0] HASH_XOR = 32'hBB5D_D64A;

   localparam logic [7:0] UPPER_LO = 8'h41;
   localparam logic [7:0] UPPER_HI = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [ROT_W-1:0] ROT_STEP = 5'd7;

   // register indexes on the csr port
   localparam logic CSR_FOLD_CASE   = 1'b0;
   localparam logic CSR_SIGN_EXTEND = 1'b1;

   // one byte after the multiply stage, ready for the accumulator
   typedef struct packed {
      logic              has_byte;
      logic              last;
      logic [HASH_W-1:0] term;   // c*K1 + K2
      logic [HASH_W-1:0] mask;   // K3 rotated right by c[4:0]
   } srx_mix_type;

   function automatic logic [HASH_W-1:0] rotr(input logic [HASH_W-1:0] v,
                                              input logic [ROT_W-1:0] n);
      logic [2*HASH_W-1:0] w;
      w = {v, v} >> n;
      return w[HASH_W-1:0];
   endfunction

endpackage

@@ design/srx_front.sv @@
module srx_front import srx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fold_case,
   input  logic              sign_extend_bytes,
   input  logic              in_valid,
   input  logic [7:0]        data_byte,
   input  logic              has_byte,
   input  logic              last,
   output logic              in_ready,
   output logic              mix_valid,
   output srx_mix_type       mix,
   input  logic              mix_ready
);

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   logic              s1_neg_ff;
   logic              s1_has_ff;
   logic              s1_last_ff;
   logic              s2_valid_ff, s2_valid_in;
   srx_mix_type       s2_mix_ff, s2_mix_in;

   logic              neg;
   logic              is_upper;
   logic [7:0]        byte_prep;
   logic [HASH_W-1:0] c_wide;
   logic [HASH_W-1:0] prod;
   logic              s1_ready;
   logic              s2_ready;

   // byte widening and case folding ahead of the input register
   assign neg       = sign_extend_bytes & data_byte[7];
   assign is_upper  = fold_case && !neg && (data_byte >= UPPER_LO) && (data_byte <= UPPER_HI);
   assign byte_prep = is_upper ? (data_byte | CASE_BIT) : data_byte;

   assign s2_ready = !s2_valid_ff || mix_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // constant multiply on the widened byte, wraps mod 2^32
   assign c_wide = {{(HASH_W-8){s1_neg_ff}}, s1_byte_ff};
   assign prod   = c_wide * HASH_MUL;

   always_comb begin
      s2_mix_in.has_byte = s1_has_ff;
      s2_mix_in.last     = s1_last_ff;
      s2_mix_in.term     = prod + HASH_ADD;
      s2_mix_in.mask     = rotr(HASH_XOR, s1_byte_ff[ROT_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_byte_ff <= byte_prep;
         s1_neg_ff  <= neg;
         s1_has_ff  <= has_byte;
         s1_last_ff <= last;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_mix_ff <= s2_mix_in;
      end
   end

   assign mix_valid = s2_valid_ff;
   assign mix       = s2_mix_ff;

endmodule

@@ design/srx_accum.sv @@
module srx_accum import srx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              mix_valid,
   input  srx_mix_type       mix,
   output logic              mix_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HASH_W-1:0] rsp_hash_value
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [ROT_W-1:0]  rot_ff, rot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff;

   logic              out_ready;
   logic              go;
   logic [HASH_W-1:0] sum;
   logic [HASH_W-1:0] hash_new;
   logic [ROT_W-1:0]  rot_new;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   // a non-last byte never needs the output slot
   assign mix_ready = !mix.last || out_ready;
   assign go        = mix_valid && mix_ready;

   assign sum      = hash_ff + mix.term;
   assign hash_new = mix.has_byte ? (rotr(sum, rot_ff) ^ mix.mask) : hash_ff;
   assign rot_new  = mix.has_byte ? (rot_ff + ROT_STEP) : rot_ff;

   always_comb begin
      hash_in      = hash_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (go) begin
         if (mix.last) begin
            hash_in      = '0;
            rot_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            hash_in = hash_new;
            rot_in  = rot_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && mix.last) begin
         rsp_hash_ff <= hash_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

@@ design/string_hash_rotate_xor.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_data_byte[7:0], req_has_byte, req_last
// rsp      out        rsp_valid/rsp_stall  rsp_hash_value[31:0]
// csr      in         csr_write_en         csr_index, csr_data
//
// One byte per cycle sustained while req_stall is low. A transfer on req passes
// the input register and the multiply register before it reaches the hash
// register; a last item puts its hash into the rsp register instead, and
// rsp_valid rises with it. The recurrence is one add, a rotate and an xor on the hash.
// Reset is synchronous: empties the pipe, clears the hash and rotation, and
// sets fold_case = 0, sign_extend_bytes = 1.
// req_stall rises only when a result sits in the rsp register under rsp_stall
// and a last item is waiting behind it; plain bytes keep flowing.
module string_hash_rotate_xor import srx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_has_byte,
   input  logic              req_last,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HASH_W-1:0] rsp_hash_value,
   // configuration
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic              csr_data
);

   logic        fold_case_ff, fold_case_in;
   logic        sign_ext_ff, sign_ext_in;
   logic        in_ready;
   logic        mix_valid;
   logic        mix_ready;
   srx_mix_type mix;

   // config registers; the user must write them only while idle, the block does not enforce it
   always_comb begin
      fold_case_in = fold_case_ff;
      sign_ext_in  = sign_ext_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FOLD_CASE:   fold_case_in = csr_data;
            CSR_SIGN_EXTEND: sign_ext_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_case_ff <= 1'b0;
         sign_ext_ff  <= 1'b1;
      end else begin
         fold_case_ff <= fold_case_in;
         sign_ext_ff  <= sign_ext_in;
      end
   end

   // byte prep, input register, multiply stage
   srx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .fold_case         (fold_case_ff),
      .sign_extend_bytes (sign_ext_ff),
      .in_valid          (req_valid),
      .data_byte         (req_data_byte),
      .has_byte          (req_has_byte),
      .last              (req_last),
      .in_ready          (in_ready),
      .mix_valid         (mix_valid),
      .mix               (mix),
      .mix_ready         (mix_ready)
   );

   // running hash, rotation counter, result register
   srx_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .mix_valid      (mix_valid),
      .mix            (mix),
      .mix_ready      (mix_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   assign req_stall = !in_ready;

endmodule

@@ design/srx_checker.sv @@
module srx_checker import srx_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [HASH_W-1:0] rsp_hash_value
);

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hash_value))
      else $error("rsp_hash_value changed under stall");

   // backpressure on req only comes from a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

endmodule

bind string_hash_rotate_xor srx_checker u_srx_checker (.*);

@@ tb/tb_string_hash_rotate_xor.sv @@
`timescale 1ns / 1ps

module tb_string_hash_rotate_xor;
   import srx_pkg::*;

   // Run ends with a failure if it goes on past this many clocks.
   localparam int unsigned CYCLE_LIMIT = 300000;
   // Settle wait after the last hash, long enough for the input and multiply registers to empty.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned MAX_PRINTS = 30;

   // ---------------------------------------------------------------------
   // Hash predictor and store of expected hash values
   // ---------------------------------------------------------------------
   class hash_scoreboard;
      logic [HASH_W-1:0] acc_hash;
      logic [ROT_W-1:0]  acc_rot;
      logic              fold_case;
      logic              sign_extend;
      logic [HASH_W-1:0] expected_hashes[$];
      int unsigned       errors;

      function new();
         acc_hash    = '0;
         acc_rot     = '0;
         fold_case   = 1'b0;
         sign_extend = 1'b1;
         errors      = 0;
      endfunction

      function logic [HASH_W-1:0] ror32(logic [HASH_W-1:0] v, logic [ROT_W-1:0] n);
         if (n == '0)
            return v;
         return (v >> n) | (v << (HASH_W - n));
      endfunction

      function void apply_csr(logic idx, logic val);
         if (idx == CSR_FOLD_CASE)
            fold_case = val;
         else
            sign_extend = val;
      endfunction

      // one accepted req transfer
      function void note_transfer(logic [7:0] b, logic hb, logic lst);
         logic [HASH_W-1:0] c;
         if (hb) begin
            c = (sign_extend && b[7]) ? {24'hFF_FFFF, b} : {24'h00_0000, b};
            if (fold_case && c >= {24'h0, UPPER_LO} && c <= {24'h0, UPPER_HI})
               c = c | {24'h0, CASE_BIT};
            acc_hash = acc_hash + c * HASH_MUL + HASH_ADD;
            acc_hash = ror32(acc_hash, acc_rot);
            acc_hash = acc_hash ^ ror32(HASH_XOR, c[ROT_W-1:0]);
            acc_rot  = acc_rot + ROT_STEP;
         end
         if (lst) begin
            expected_hashes.push_back(acc_hash);
            acc_hash = '0;
            acc_rot  = '0;
         end
      endfunction

      task report_mismatch(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
         if (errors < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %08h expected %08h", $time, what, got, want);
         errors++;
      endtask

      // one accepted rsp transfer
      task check_hash(logic [HASH_W-1:0] got);
         logic [HASH_W-1:0] want;
         if (expected_hashes.size() == 0) begin
            report_mismatch("hash with no closed message", got, '0);
         end else begin
            want = expected_hashes.pop_front();
            if (got !== want)
               report_mismatch("hash_value", got, want);
         end
      endtask

      function int unsigned pending();
         return expected_hashes.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_data_byte;
   logic              req_has_byte;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [HASH_W-1:0] rsp_hash_value;
   logic              csr_write_en;
   logic              csr_index;
   logic              csr_data;

   hash_scoreboard sb = new();

   // idle / stall rates in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned cycle_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   string_hash_rotate_xor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------------
   // Result side: check each rsp transfer, then pick the next stall value.
   // Values read here are the ones that held up to this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_hash(rsp_hash_value);
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("string_hash_rotate_xor verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // One req transfer, with random idle cycles ahead of it. Valid stays high
   // from one item into the next when no gap is drawn.
   task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_has_byte  <= hb;
      req_last      <= lst;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_transfer(b, hb, lst);
   endtask

   // Sender holds off until every hash has come out and the pipe has
   // emptied of bytes that close no message.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; write enable stays high across the pair.
   task automatic write_config(input logic fold, input logic sext);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FOLD_CASE;
      csr_data     <= fold;
      @(posedge clock);
      csr_index    <= CSR_SIGN_EXTEND;
      csr_data     <= sext;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.apply_csr(CSR_FOLD_CASE, fold);
      sb.apply_csr(CSR_SIGN_EXTEND, sext);
   endtask

   // Byte mix leaning toward the interesting ranges: letters and their
   // borders for case folding, high bytes for sign extension.
   function automatic logic [7:0] pick_byte();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         0, 1:    return 8'($urandom_range(8'h5B, 8'h40));
         2, 3:    return 8'($urandom_range(8'hFF, 8'h80));
         4:       return 8'($urandom_range(8'h7A, 8'h61));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly whole messages of random length and content, closed either by a
   // final byte or by an empty last item; the rest is idle items and stray
   // single transfers. n_items counts only items the block acts on.
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(19) == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         end else if ($urandom_range(9) == 0) begin
            send_item(pick_byte(), 1'b1, 1'($urandom_range(1)));
            sent++;
         end else begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
            repeat (len) begin
               send_item(pick_byte(), 1'b1, 1'b0);
               sent++;
            end
            send_item(pick_byte(), 1'($urandom_range(1)), 1'b1);
            sent++;
         end
         if ($urandom_range(59) == 0)
            wait_drained();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_has_byte  <= 1'b0;
      req_last      <= 1'b0;
      rsp_stall     <= 1'b0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_FOLD_CASE;
      csr_data      <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed, reset config: no folding, bytes sign-extended.
      send_item(8'h00, 1'b0, 1'b1);      // empty message right after reset -> 0
      send_item(8'hAB, 1'b0, 1'b0);      // idle item, nothing happens
      send_item(8'h00, 1'b1, 1'b1);      // zero byte, zero rotation
      send_item(8'hFF, 1'b1, 1'b1);      // all ones, sign-extended
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);      // letters unfolded here
      send_item(8'h5A, 1'b1, 1'b0);
      send_item(8'h40, 1'b1, 1'b0);      // rotation wraps past 31 on this byte
      send_item(8'h5B, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);      // close with no byte
      wait_drained();

      // Folding on, zero extension.
      write_config(1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h5A, 1'b1, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'hC1, 1'b1, 1'b0);      // high byte, low bits look like a letter
      send_item(8'hFF, 1'b1, 1'b1);
      wait_drained();

      // Folding with sign extension: high bytes never fold.
      write_config(1'b1, 1'b1);
      send_item(8'hC1, 1'b1, 1'b0);
      send_item(8'hDA, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h4D, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);      // empty message after a close -> 0
      wait_drained();

      // Random phases, each under its own config and idling pattern.
      write_config(1'b0, 1'b0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(350);
      wait_drained();

      write_config(1'b1, 1'b1);
      send_idle_pct = 57;
      rsp_stall_pct = 0;
      run_random(350);
      wait_drained();

      write_config(1'b0, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 57;
      run_random(350);
      wait_drained();

      write_config(1'b1, 1'b0);
      send_idle_pct = 28;
      rsp_stall_pct = 28;
      run_random(350);

      // Wind down: let the last hashes come out, then let the pipe settle.
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("string_hash_rotate_xor verification clean");
      else
         $display("string_hash_rotate_xor verification failed");
      $finish;
   end

endmodule

@@ string_hash_rotate_xor.f @@
design/srx_pkg.sv
design/srx_front.sv
design/srx_accum.sv
design/string_hash_rotate_xor.sv
design/srx_checker.sv
tb/tb_string_hash_rotate_xor.sv
